/* hw/rtl/mersenne_twister_generator_macros.svh */
// assertion macros for the mersenne twister generator
`ifndef MERSENNE_TWISTER_GENERATOR_MACROS_SVH
`define MERSENNE_TWISTER_GENERATOR_MACROS_SVH

// same-cycle implication, reset disables the check
`define MTG_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, reset disables the check
`define MTG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/mt_gen_pkg.sv */
// constants and word functions of the mt19937 generator
`default_nettype none

package mt_gen_pkg;

	localparam int WordW            = 32;
	localparam int StateWordsDef    = 624;
	localparam int MiddleOffsetDef  = 397;

	localparam logic [WordW-1:0] TwistMatrix = 32'h9908_b0df;
	localparam logic [WordW-1:0] UpperMask   = 32'h8000_0000;
	localparam logic [WordW-1:0] LowerMask   = 32'h7fff_ffff;
	localparam logic [WordW-1:0] TemperB     = 32'h9d2c_5680;
	localparam logic [WordW-1:0] TemperC     = 32'hefc6_0000;
	localparam logic [WordW-1:0] FillMult    = 32'd69069;
	localparam logic [WordW-1:0] SeedReset   = 32'd4357;

	typedef logic [WordW-1:0] word_t;

	// new value of word k from word k, word k+1 and word k+offset
	function automatic word_t twist(input word_t cur, input word_t nxt, input word_t mid);
		word_t y;
		word_t v;
		y = (cur & UpperMask) | (nxt & LowerMask);
		v = mid ^ (y >> 1);
		if (y[0]) begin
			v = v ^ TwistMatrix;
		end
		return v;
	endfunction

	function automatic word_t temper(input word_t w);
		word_t y;
		y = w;
		y = y ^ (y >> 11);
		y = y ^ ((y << 7) & TemperB);
		y = y ^ ((y << 15) & TemperC);
		y = y ^ (y >> 18);
		return y;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/mersenne_twister_generator.sv */
// mt19937 generator top level: state memory, fill sequencer and on-the-fly twist
`default_nettype none

// MT19937 word generator. Each transfer on the input stream with request set
// returns one tempered 32-bit word on the output stream; a transfer with request
// clear is taken and gives nothing. The state sits in one memory with a write
// port and two registered read ports. The first request after reset or after a
// seed write first fills the state from the seed with the 69069 recurrence, one
// word a cycle through the single write port. After that each word runs through
// the steps take request, read words k+1 and k+397, twist word k and write it
// back while the tempered result goes to the output register; a new request is
// taken only after that write-back. The output register lets the next request
// in while a word still waits; a stalled output holds back only the write-back
// step. The seed is written through the cfg channel while idle; a pending seed
// write holds off requests for that cycle.
module mersenne_twister_generator #(
	parameter int StateWords   = mt_gen_pkg::StateWordsDef,
	parameter int MiddleOffset = mt_gen_pkg::MiddleOffsetDef
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// seed register write
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [31:0] cfg_data,     // seed
	// requests
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata, // [0] request, [7:1] zero
	// random words
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata  // [31:0] random_word
);

	localparam int IdxW = $clog2(StateWords);
	localparam logic [IdxW-1:0] LastIdx = IdxW'(StateWords - 1);

	typedef enum logic [1:0] {
		S_IDLE,
		S_FILL,
		S_READ,
		S_CALC
	} state_t;

	state_t              state_q;
	logic                seeded_q;
	logic [IdxW-1:0]     idx_q;
	logic [IdxW-1:0]     fill_idx_q;
	mt_gen_pkg::word_t   fill_word_q;
	mt_gen_pkg::word_t   seed_q;
	mt_gen_pkg::word_t   cur_q;
	mt_gen_pkg::word_t   m_data_q;
	logic                m_valid_q;

	mt_gen_pkg::word_t   mem [StateWords];
	mt_gen_pkg::word_t   rd_nxt_q;
	mt_gen_pkg::word_t   rd_mid_q;

	logic [IdxW-1:0]     addr_nxt;
	logic [IdxW:0]       mid_sum;
	logic [IdxW-1:0]     addr_mid;
	logic                in_fire;
	logic                cfg_fire;
	logic                calc_fire;
	logic                fill_last;
	mt_gen_pkg::word_t   twisted;
	logic                mem_we;
	logic [IdxW-1:0]     mem_wa;
	mt_gen_pkg::word_t   mem_wd;
	logic                fill_end;
	logic                fill_handed;
	logic                in_calc;

	assign s_axis_tready = (state_q == S_IDLE) && !cfg_valid;
	assign cfg_ready     = (state_q == S_IDLE);
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	assign in_fire   = s_axis_tvalid && s_axis_tready;
	assign cfg_fire  = cfg_valid && cfg_ready;
	assign calc_fire = (state_q == S_CALC) && (!m_valid_q || m_axis_tready);
	assign fill_last = (fill_idx_q == LastIdx);

	// neighbour and middle word addresses, both wrap round the state
	assign addr_nxt = (idx_q == LastIdx) ? '0 : IdxW'(idx_q + 1'b1);
	assign mid_sum  = {1'b0, idx_q} + (IdxW+1)'(MiddleOffset);
	assign addr_mid = (mid_sum >= (IdxW+1)'(StateWords))
		? IdxW'(mid_sum - (IdxW+1)'(StateWords)) : mid_sum[IdxW-1:0];

	assign twisted = mt_gen_pkg::twist(cur_q, rd_nxt_q, rd_mid_q);

	assign mem_we = (state_q == S_FILL) || calc_fire;
	assign mem_wa = (state_q == S_FILL) ? fill_idx_q : idx_q;
	assign mem_wd = (state_q == S_FILL) ? fill_word_q : twisted;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
	end

	always_ff @(posedge clk) begin
		rd_nxt_q <= mem[addr_nxt];
		rd_mid_q <= mem[addr_mid];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			seeded_q    <= 1'b0;
			idx_q       <= '0;
			fill_idx_q  <= '0;
			fill_word_q <= '0;
			seed_q      <= mt_gen_pkg::SeedReset;
			cur_q       <= '0;
			m_data_q    <= '0;
			m_valid_q   <= 1'b0;
		end else begin
			if (calc_fire) begin
				m_valid_q <= 1'b1;
				m_data_q  <= mt_gen_pkg::temper(twisted);
			end else if (m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (cfg_fire) begin
						seed_q   <= cfg_data;
						seeded_q <= 1'b0;
					end
					if (in_fire && s_axis_tdata[0]) begin
						if (seeded_q) begin
							state_q <= S_READ;
						end else begin
							fill_idx_q  <= '0;
							fill_word_q <= seed_q;
							state_q     <= S_FILL;
						end
					end
				end
				S_FILL: begin
					fill_word_q <= mt_gen_pkg::WordW'(fill_word_q * mt_gen_pkg::FillMult);
					fill_idx_q  <= IdxW'(fill_idx_q + 1'b1);
					if (fill_last) begin
						seeded_q <= 1'b1;
						idx_q    <= '0;
						cur_q    <= seed_q;
						state_q  <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_CALC;
				end
				S_CALC: begin
					// word k+1 read now is the current word of the next step
					if (calc_fire) begin
						cur_q   <= rd_nxt_q;
						idx_q   <= addr_nxt;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign fill_end    = (state_q == S_FILL) && fill_last;
	assign fill_handed = seeded_q && (idx_q == '0) && (state_q == S_READ);
	assign in_calc     = (state_q == S_CALC);

`include "mersenne_twister_generator_macros.svh"

	`MTG_ASSERT_SAME(a_idx_range, clk, arst_n, 1'b1, idx_q <= LastIdx, "index beyond state")
	`MTG_ASSERT_NEXT(a_fill_done, clk, arst_n, fill_end, fill_handed, "bad fill handover")
	`MTG_ASSERT_NEXT(a_cfg_unseed, clk, arst_n, cfg_fire, !seeded_q, "seed write kept seeded")
	`MTG_ASSERT_SAME(a_out_calc, clk, arst_n, $rose(m_valid_q), $past(in_calc), "stray result")

endmodule

`default_nettype wire
